// ===== hdl/lwc_pkg.sv =====
// Shared widths, types and register codes for the line window clipper.
package lwc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;

  // Derived widths
  localparam int CW    = COORD_BITS;           // coordinate
  localparam int TW    = T_FRAC_BITS + 1;      // t in Q1.F
  localparam int NW    = CW + T_FRAC_BITS + 1; // dividend / remainder
  localparam int DSW   = CW + TW + 1;          // shifted divisor
  localparam int STEPS = TW + 1;               // divider steps incl. overflow bit
  localparam int PW    = TW + CW + 2;          // t * d product
  localparam int TDW   = ((4 * CW + 7) / 8) * 8;

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] T_MAX = {TW{1'b1}};

  // Configuration register indexes
  localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_WIN_BOTTOM = 2'd1;
  localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
  localparam logic [1:0] REG_WIN_TOP    = 2'd3;

  localparam logic [CW-1:0] WIN_LEFT_RST   = CW'(0);
  localparam logic [CW-1:0] WIN_BOTTOM_RST = CW'(0);
  localparam logic [CW-1:0] WIN_RIGHT_RST  = CW'(639);
  localparam logic [CW-1:0] WIN_TOP_RST    = CW'(479);

  // Window bounds
  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] bottom;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] top;
  } win_t;

  // Item state while the edge ratios are divided, one lane per window edge
  typedef struct packed {
    logic signed [CW-1:0]     x1;
    logic signed [CW-1:0]     y1;
    logic signed [CW:0]       dx;
    logic signed [CW:0]       dy;
    logic [3:0][NW-1:0]       rem;
    logic [3:0][DSW-1:0]      den;
    logic [3:0][STEPS-1:0]    quo;
    logic [3:0]               entry;  // p<0, q<=0: bounds t1
    logic [3:0]               leave;  // p>0, q>=0: bounds t2
    logic                     reject;
  } div_t;

endpackage

// ===== hdl/lwc_prep.sv =====
// Edge terms, classification and dividend setup (two register stages).
module lwc_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lwc_pkg::win_t         win,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [lwc_pkg::CW-1:0] sx,
  input  logic [lwc_pkg::CW-1:0] sy,
  input  logic [lwc_pkg::CW-1:0] ex,
  input  logic [lwc_pkg::CW-1:0] ey,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lwc_pkg::div_t         out_data
);
  import lwc_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0]    x1;
    logic signed [CW-1:0]    y1;
    logic signed [CW:0]      dx;
    logic signed [CW:0]      dy;
    logic [3:0][CW:0]        q;
  } edge_t;

  edge_t a_r, a_nxt;
  logic  a_v_r;
  logic  a_ready;
  div_t  b_r, b_nxt;
  logic  b_v_r;

  assign out_valid = b_v_r;
  assign out_data  = b_r;
  assign a_ready   = !b_v_r || out_ready;
  assign in_ready  = !a_v_r || a_ready;

  // Stage A: deltas and window distances
  always_comb begin
    logic signed [CW:0] x1e, y1e;
    x1e = {sx[CW-1], sx};
    y1e = {sy[CW-1], sy};
    a_nxt.x1   = sx;
    a_nxt.y1   = sy;
    a_nxt.dx   = {ex[CW-1], ex} - x1e;
    a_nxt.dy   = {ey[CW-1], ey} - y1e;
    a_nxt.q[0] = x1e - {win.left[CW-1], win.left};
    a_nxt.q[1] = {win.right[CW-1], win.right} - x1e;
    a_nxt.q[2] = y1e - {win.bottom[CW-1], win.bottom};
    a_nxt.q[3] = {win.top[CW-1], win.top} - y1e;
  end

  // Stage B: lane roles, magnitudes, rounded dividend
  always_comb begin
    logic signed [CW:0] p, q;
    logic [CW:0]        pa, qa;
    logic [CW-1:0]      pm, qm;
    b_nxt.x1     = a_r.x1;
    b_nxt.y1     = a_r.y1;
    b_nxt.dx     = a_r.dx;
    b_nxt.dy     = a_r.dy;
    b_nxt.reject = 1'b0;
    for (int l = 0; l < 4; l++) begin
      p  = (l < 2) ? a_r.dx : a_r.dy;
      if (l % 2 == 0) p = -p;
      q  = a_r.q[l];
      pa = p[CW] ? -p : p;
      qa = q[CW] ? -q : q;
      pm = pa[CW-1:0];
      qm = qa[CW-1:0];
      b_nxt.entry[l] = p[CW] && (q[CW] || q == '0);
      b_nxt.leave[l] = !p[CW] && p != '0 && !q[CW];
      if ((p == '0 || !p[CW]) && q[CW]) b_nxt.reject = 1'b1;
      b_nxt.rem[l] = NW'({qm, {T_FRAC_BITS{1'b0}}}) + NW'(pm >> 1);
      b_nxt.den[l] = DSW'(pm) << STEPS;
      b_nxt.quo[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (in_ready) a_v_r <= in_valid;
      if (a_ready)  b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) a_r <= a_nxt;
    if (a_ready && a_v_r)     b_r <= b_nxt;
  end

endmodule

// ===== hdl/lwc_div_step.sv =====
// One restoring-division step, one quotient bit, for all four lanes.
module lwc_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lwc_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lwc_pkg::div_t out_data
);
  import lwc_pkg::*;

  div_t d_r, d_nxt;
  logic v_r;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // Divisor moves down one bit; subtract where it fits
  always_comb begin
    logic [DSW-1:0] dsh;
    logic           fit;
    d_nxt = in_data;
    for (int l = 0; l < 4; l++) begin
      dsh = in_data.den[l] >> 1;
      fit = DSW'(in_data.rem[l]) >= dsh;
      d_nxt.den[l] = dsh;
      d_nxt.rem[l] = fit ? in_data.rem[l] - dsh[NW-1:0] : in_data.rem[l];
      d_nxt.quo[l] = {in_data.quo[l][STEPS-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) d_r <= d_nxt;
  end

endmodule

// ===== hdl/lwc_finish.sv =====
// Entry/exit selection, endpoint multiply, rounding; last stage is the output register.
module lwc_finish (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lwc_pkg::div_t          in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   visible,
  output logic [lwc_pkg::CW-1:0] csx,
  output logic [lwc_pkg::CW-1:0] csy,
  output logic [lwc_pkg::CW-1:0] cex,
  output logic [lwc_pkg::CW-1:0] cey
);
  import lwc_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [TW-1:0]        t1;
    logic [TW-1:0]        t2;
    logic                 reject;
  } sel_t;

  typedef struct packed {
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic [3:0][PW-1:0]    prod;  // t1*dx, t1*dy, t2*dx, t2*dy
    logic                  reject;
  } mul_t;

  typedef struct packed {
    logic          vis;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } res_t;

  sel_t s_r, s_nxt;
  mul_t m_r, m_nxt;
  res_t o_r, o_nxt;
  logic s_v_r, m_v_r, o_v_r;
  logic s_ready, m_ready;

  assign m_ready   = !o_v_r || out_ready;
  assign s_ready   = !m_v_r || m_ready;
  assign in_ready  = !s_v_r || s_ready;
  assign out_valid = o_v_r;
  assign visible   = o_r.vis;
  assign csx       = o_r.sx;
  assign csy       = o_r.sy;
  assign cex       = o_r.ex;
  assign cey       = o_r.ey;

  // Stage 1: t1 = max over entry ratios, t2 = min over exit ratios
  always_comb begin
    logic [TW-1:0] r;
    s_nxt.x1     = in_data.x1;
    s_nxt.y1     = in_data.y1;
    s_nxt.dx     = in_data.dx;
    s_nxt.dy     = in_data.dy;
    s_nxt.reject = in_data.reject;
    s_nxt.t1     = '0;
    s_nxt.t2     = T_ONE;
    for (int l = 0; l < 4; l++) begin
      r = in_data.quo[l][STEPS-1] ? T_MAX : in_data.quo[l][TW-1:0];
      if (in_data.entry[l] && r > s_nxt.t1) s_nxt.t1 = r;
      if (in_data.leave[l] && r < s_nxt.t2) s_nxt.t2 = r;
    end
  end

  // Stage 2: crossed-parameter check and the four products
  always_comb begin
    logic signed [TW:0] t1s, t2s;
    t1s = {1'b0, s_r.t1};
    t2s = {1'b0, s_r.t2};
    m_nxt.x1      = s_r.x1;
    m_nxt.y1      = s_r.y1;
    m_nxt.reject  = s_r.reject || (s_r.t1 > s_r.t2);
    m_nxt.prod[0] = PW'(t1s * s_r.dx);
    m_nxt.prod[1] = PW'(t1s * s_r.dy);
    m_nxt.prod[2] = PW'(t2s * s_r.dx);
    m_nxt.prod[3] = PW'(t2s * s_r.dy);
  end

  // Stage 3: round to nearest (ties up), add base, zero on reject
  always_comb begin
    logic signed [PW-1:0] v;
    logic [3:0][CW-1:0]   c;
    for (int l = 0; l < 4; l++) begin
      v    = $signed(m_r.prod[l]) + $signed(PW'(T_ONE >> 1));
      v    = v >>> T_FRAC_BITS;
      c[l] = v[CW-1:0] + ((l % 2 == 0) ? m_r.x1 : m_r.y1);
    end
    o_nxt.vis = !m_r.reject;
    o_nxt.sx  = m_r.reject ? '0 : c[0];
    o_nxt.sy  = m_r.reject ? '0 : c[1];
    o_nxt.ex  = m_r.reject ? '0 : c[2];
    o_nxt.ey  = m_r.reject ? '0 : c[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (in_ready) s_v_r <= in_valid;
      if (s_ready)  m_v_r <= s_v_r;
      if (m_ready)  o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s_r <= s_nxt;
    if (s_ready && s_v_r)     m_r <= m_nxt;
    if (m_ready && m_v_r)     o_r <= o_nxt;
  end

endmodule

// ===== hdl/line_window_clipper.sv =====
// Top level: Liang-Barsky segment clipper against a configurable window.
//
//  channel  | direction | contents
//  in_*     | slave     | one segment: start and end points
//  out_*    | master    | clipped endpoints, visible flag in tuser
//  cfg_*    | write     | window registers left, bottom, right, top
//
// One segment per cycle while out_tready does not stall the pipeline.
// Most of the pipeline depth comes from the restoring divider, one quotient bit per stage.
// Each stage holds while its successor is full and stalled, so bubbles close up.
// rst_n is synchronous; it clears valids and loads the default window.
module line_window_clipper (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wen,
  input  logic [1:0]              cfg_addr,
  input  logic [lwc_pkg::CW-1:0]  cfg_wdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [lwc_pkg::TDW-1:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [lwc_pkg::TDW-1:0] out_tdata,  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic                    out_tuser   // visible
);
  import lwc_pkg::*;

  win_t win_r;
  div_t chain [0:STEPS];
  logic chain_v [0:STEPS];
  logic chain_rdy [0:STEPS];
  logic [CW-1:0] csx, csy, cex, cey;

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= WIN_LEFT_RST;
      win_r.bottom <= WIN_BOTTOM_RST;
      win_r.right  <= WIN_RIGHT_RST;
      win_r.top    <= WIN_TOP_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_WIN_LEFT:   win_r.left   <= cfg_wdata;
        REG_WIN_BOTTOM: win_r.bottom <= cfg_wdata;
        REG_WIN_RIGHT:  win_r.right  <= cfg_wdata;
        REG_WIN_TOP:    win_r.top    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lwc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sx        (in_tdata[CW-1:0]),
    .sy        (in_tdata[2*CW-1:CW]),
    .ex        (in_tdata[3*CW-1:2*CW]),
    .ey        (in_tdata[4*CW-1:3*CW]),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_data  (chain[0])
  );

  // Divider pipeline
  for (genvar s = 0; s < STEPS; s++) begin : g_div
    lwc_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[s]),
      .in_ready  (chain_rdy[s]),
      .in_data   (chain[s]),
      .out_valid (chain_v[s+1]),
      .out_ready (chain_rdy[s+1]),
      .out_data  (chain[s+1])
    );
  end

  lwc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[STEPS]),
    .in_ready  (chain_rdy[STEPS]),
    .in_data   (chain[STEPS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .visible   (out_tuser),
    .csx       (csx),
    .csy       (csy),
    .cex       (cex),
    .cey       (cey)
  );

  assign out_tdata = TDW'({cey, cex, csy, csx});

endmodule
